// ===== rtl/core/sipq_pkg.sv =====
// sipq_pkg: shared types and codes for the sorted-insert priority queue
// depends on nothing; used by sorted_insert_priority_queue_top
`timescale 1ns / 1ps

package sipq_pkg;

	localparam int unsigned VAL_W   = 32;
	localparam int unsigned COUNT_W = 7;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} sipq_cmd_t;

	typedef struct packed {
		sipq_cmd_t                command;
		logic signed [VAL_W-1:0]  value;
	} sipq_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  front_value;
		logic [COUNT_W-1:0]       entry_count;
		logic                     rejected;
	} sipq_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_WR,
		ST_POP_RD,
		ST_RESULT
	} sipq_state_t;

endpackage

// ===== rtl/core/sipq_ram.sv =====
// sipq_ram: one-write one-read synchronous memory, registered read data
// depends on nothing; holds the queue values for sorted_insert_priority_queue_top
`timescale 1ns / 1ps

module sipq_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32,
	parameter int unsigned AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/sorted_insert_priority_queue_top.sv =====
// sorted_insert_priority_queue_top: bounded priority queue over a single memory
// depends on sipq_pkg and sipq_ram
`timescale 1ns / 1ps

// usage
// - request channel (req_valid / req_stall / req_word): one word per command,
//   insert places value at its sorted spot, pop drops the largest value
// - response channel (rsp_valid / rsp_stall / rsp_word): exactly one word per
//   request: largest value held (0 when empty), entry count, reject flag
// - values sit in ascending order in the memory, largest at count-1, so a pop
//   only moves the count and reads the new top once
// - an insert walks down from the top one entry per cycle through the memory
//   port (read, compare, write back shifted) past every held value larger than
//   the new one
// - pop of two or more values passes through ST_POP_RD to read the new top; empty
//   pop, pop of the last value, first insert, rejected insert go straight to ST_RESULT
// - one request is in work at a time; req_stall is high from acceptance until
//   the response is loaded into the output register
// - a response waiting in the output register under rsp_stall holds; the next
//   request can still be taken, its response waits until the register frees
// - reset clears the count and control state; the memory is not cleared since
//   only entries below the count are ever used
module sorted_insert_priority_queue_top
	import sipq_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  sipq_req_t req_word,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output sipq_rsp_t rsp_word
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sipq_state_t state_q, state_d;

	logic [CW-1:0]          cnt_q;
	logic [AW-1:0]          pos_q;     // slot that takes the next shifted value
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] front_q;
	logic                   rej_q;

	logic                   rsp_valid_q;
	sipq_rsp_t              rsp_q;

	// memory port
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [VAL_W-1:0]       ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [VAL_W-1:0]       ram_rdata;

	logic accept;
	logic is_full;
	logic is_empty;
	logic more_than_one;
	logic larger;          // stored entry larger than the new value
	logic pos_last;        // pos_q is 1: the next shift reaches slot 0
	logic rsp_free;

	assign accept        = req_valid && (state_q == ST_IDLE);
	assign req_stall     = (state_q != ST_IDLE);
	assign is_full       = (cnt_q >= CW'(DEPTH));
	assign is_empty      = (cnt_q == '0);
	assign more_than_one = (cnt_q > CW'(1));
	assign larger        = ($signed(ram_rdata) > val_q);
	assign pos_last      = (pos_q == AW'(1));
	assign rsp_free      = !rsp_valid_q || !rsp_stall;

	sipq_ram #(
		.DEPTH (DEPTH),
		.WIDTH (VAL_W),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_word.command == CMD_INSERT && !is_full && !is_empty) begin
						state_d = ST_INS_CMP;
					end else if (req_word.command == CMD_POP && more_than_one) begin
						state_d = ST_POP_RD;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_INS_CMP: begin
				priority if (larger && pos_last) begin
					state_d = ST_INS_WR;
				end else if (larger) begin
					state_d = ST_INS_CMP;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_INS_WR: state_d = ST_RESULT;
			ST_POP_RD: state_d = ST_RESULT;
			ST_RESULT: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_word.command == CMD_INSERT && !is_full) begin
					if (is_empty) begin
						// first value goes straight to slot 0
						ram_we    = 1'b1;
						ram_wdata = req_word.value;
					end else begin
						ram_raddr = AW'(cnt_q - CW'(1));
					end
				end else if (accept && req_word.command == CMD_POP && more_than_one) begin
					// the new top after the pop
					ram_raddr = AW'(cnt_q - CW'(2));
				end
			end
			ST_INS_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				if (larger) begin
					// shift the larger entry up one slot, fetch the next one down
					ram_wdata = ram_rdata;
					ram_raddr = pos_q - AW'(2);
				end else begin
					ram_wdata = val_q;
				end
			end
			ST_INS_WR: begin
				// new value is the smallest: it lands in slot 0
				ram_we    = 1'b1;
				ram_wdata = val_q;
			end
			ST_POP_RD, ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rej_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rej_q <= 1'b0;
				if (req_word.command == CMD_INSERT) begin
					if (is_full) begin
						rej_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end else if (!is_empty) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= req_word.value;
			pos_q <= AW'(cnt_q);
			if (req_word.command == CMD_INSERT && !is_full) begin
				if (is_empty || req_word.value > front_q) begin
					front_q <= req_word.value;
				end
			end
		end
		if (state_q == ST_INS_CMP && larger) begin
			pos_q <= pos_q - AW'(1);
		end
		if (state_q == ST_POP_RD) begin
			front_q <= $signed(ram_rdata);
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESULT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && rsp_free) begin
			rsp_q.front_value <= is_empty ? '0 : front_q;
			rsp_q.entry_count <= COUNT_W'(cnt_q);
			rsp_q.rejected    <= rej_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

endmodule
